[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, ck, rn, ante, cons)
`define ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

[hw/rtl/rc4_pkg.sv]
package rc4_pkg;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] key_index;
    logic [7:0] key_byte;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic [7:0] keystream_byte;
  } out_beat_t;

  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_SCHEDULE = 2'd1;
  localparam logic [1:0] CMD_CIPHER   = 2'd2;

  localparam int KLEN_W = 9;
  localparam logic [KLEN_W-1:0] KEY_LENGTH_RESET = 9'd16;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] PC_FILL      = 4'd1;
  localparam logic [PC_W-1:0] PC_FILL_END  = 4'd2;
  localparam logic [PC_W-1:0] PC_KSA_RD_I  = 4'd3;
  localparam logic [PC_W-1:0] PC_KSA_RD_J  = 4'd4;
  localparam logic [PC_W-1:0] PC_KSA_WR_I  = 4'd5;
  localparam logic [PC_W-1:0] PC_KSA_WR_J  = 4'd6;
  localparam logic [PC_W-1:0] PC_KSA_END   = 4'd7;
  localparam logic [PC_W-1:0] PC_CIPHER    = 4'd8;
  localparam logic [PC_W-1:0] PC_CI_RD_J   = 4'd9;
  localparam logic [PC_W-1:0] PC_CI_WR_I   = 4'd10;
  localparam logic [PC_W-1:0] PC_CI_WR_J   = 4'd11;
  localparam logic [PC_W-1:0] PC_CI_RD_T   = 4'd12;
  localparam logic [PC_W-1:0] PC_CI_WAIT   = 4'd13;
  localparam logic [PC_W-1:0] PC_CI_EMIT   = 4'd14;

  typedef enum logic [1:0] {MEM_NOP, MEM_RD, MEM_WR} mem_op_t;
  typedef enum logic [2:0] {
    ADDR_I, ADDR_I_INC, ADDR_J, ADDR_J_RD, ADDR_J_RDKEY, ADDR_T
  } addr_sel_t;
  typedef enum logic [1:0] {WD_RDATA, WD_SI, WD_I} wdata_sel_t;
  typedef enum logic [1:0] {I_HOLD, I_INC, I_CLR} i_op_t;
  typedef enum logic [1:0] {J_HOLD, J_RD, J_RDKEY, J_CLR} j_op_t;
  typedef enum logic [1:0] {K_HOLD, K_CLR, K_ADV} k_op_t;
  typedef enum logic [2:0] {
    COND_NEVER, COND_ALWAYS, COND_I_NOT_LAST, COND_OUT_BUSY, COND_NOT_SCHED
  } cond_t;

  typedef struct packed {
    mem_op_t          mem_op;
    addr_sel_t        addr_sel;
    wdata_sel_t       wdata_sel;
    i_op_t            i_op;
    j_op_t            j_op;
    k_op_t            k_op;
    logic             ld_si;
    logic             ld_sj;
    logic             emit;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   key_wr;
    logic   ld_data;
    logic   sched_go;
  } ctrl_t;

  typedef struct packed {
    logic i_last;
    logic out_free;
  } status_t;

  localparam ucode_t UC_NOP = '{
    mem_op: MEM_NOP, addr_sel: ADDR_I, wdata_sel: WD_RDATA, i_op: I_HOLD,
    j_op: J_HOLD, k_op: K_HOLD, ld_si: 1'b0, ld_sj: 1'b0, emit: 1'b0,
    cond: COND_NEVER, target: PC_IDLE
  };

  // The control store. A step jumps to its target when its condition holds
  // and otherwise falls through to the next step.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = UC_NOP;
    unique case (pc)
      PC_IDLE: begin
      end
      PC_FILL: begin
        w.mem_op    = MEM_WR;
        w.addr_sel  = ADDR_I;
        w.wdata_sel = WD_I;
        w.i_op      = I_INC;
        w.cond      = COND_I_NOT_LAST;
        w.target    = PC_FILL;
      end
      PC_FILL_END: begin
        w.j_op   = J_CLR;
        w.k_op   = K_CLR;
        w.cond   = COND_NOT_SCHED;
        w.target = PC_IDLE;
      end
      PC_KSA_RD_I: begin
        w.mem_op   = MEM_RD;
        w.addr_sel = ADDR_I;
      end
      PC_KSA_RD_J: begin
        w.mem_op   = MEM_RD;
        w.addr_sel = ADDR_J_RDKEY;
        w.j_op     = J_RDKEY;
        w.ld_si    = 1'b1;
      end
      PC_KSA_WR_I: begin
        w.mem_op    = MEM_WR;
        w.addr_sel  = ADDR_I;
        w.wdata_sel = WD_RDATA;
      end
      PC_KSA_WR_J: begin
        w.mem_op    = MEM_WR;
        w.addr_sel  = ADDR_J;
        w.wdata_sel = WD_SI;
        w.i_op      = I_INC;
        w.k_op      = K_ADV;
        w.cond      = COND_I_NOT_LAST;
        w.target    = PC_KSA_RD_I;
      end
      PC_KSA_END: begin
        w.i_op   = I_CLR;
        w.j_op   = J_CLR;
        w.cond   = COND_ALWAYS;
        w.target = PC_IDLE;
      end
      PC_CIPHER: begin
        w.mem_op   = MEM_RD;
        w.addr_sel = ADDR_I_INC;
        w.i_op     = I_INC;
      end
      PC_CI_RD_J: begin
        w.mem_op   = MEM_RD;
        w.addr_sel = ADDR_J_RD;
        w.j_op     = J_RD;
        w.ld_si    = 1'b1;
      end
      PC_CI_WR_I: begin
        w.mem_op    = MEM_WR;
        w.addr_sel  = ADDR_I;
        w.wdata_sel = WD_RDATA;
        w.ld_sj     = 1'b1;
      end
      PC_CI_WR_J: begin
        w.mem_op    = MEM_WR;
        w.addr_sel  = ADDR_J;
        w.wdata_sel = WD_SI;
      end
      PC_CI_RD_T: begin
        w.mem_op   = MEM_RD;
        w.addr_sel = ADDR_T;
      end
      PC_CI_WAIT: begin
        w.cond   = COND_OUT_BUSY;
        w.target = PC_CI_WAIT;
      end
      PC_CI_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = PC_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/rc4_keystream_cipher.sv]
// Key load: accepted while idle, no beat out.
// Cipher: the input stalls until the result beat is emitted; its steps are set by the
// single-ported permutation memory (read i, read j, two writes, read t).
// Schedule: 256-entry identity fill, then 256 KSA steps (read i, read j, two writes).
// Reset is synchronous; afterwards the input stalls while the permutation memory
// is filled with the identity.
module rc4_keystream_cipher #(
  parameter int KEY_MAX_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rc4_pkg::KLEN_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rc4_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rc4_pkg::out_beat_t            out_data
);

  logic [rc4_pkg::KLEN_W-1:0] key_length_r;
  rc4_pkg::ctrl_t             ctrl;
  rc4_pkg::status_t           status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= rc4_pkg::KEY_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      key_length_r <= cfg_wr_data;
    end
  end

  rc4_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .status     (status),
    .in_stall   (in_stall),
    .ctrl       (ctrl)
  );

  rc4_dp #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_data    (in_data),
    .key_length (key_length_r),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .status     (status)
  );

endmodule

[hw/rtl/rc4_seq.sv]
`include "assert_macros.svh"

module rc4_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_command,
  input  rc4_pkg::status_t      status,
  output logic                  in_stall,
  output rc4_pkg::ctrl_t        ctrl
);

  logic [rc4_pkg::PC_W-1:0] pc_r;
  logic [rc4_pkg::PC_W-1:0] pc_nxt;
  logic                     sched_r;
  logic                     sched_nxt;
  logic                     idle;
  logic                     take;
  logic                     take_sched;
  logic                     take_cipher;
  logic                     cond_hit;
  rc4_pkg::ucode_t          uc;

  assign idle        = (pc_r == rc4_pkg::PC_IDLE);
  assign in_stall    = !idle;
  assign take        = idle && in_valid;
  assign take_sched  = take && (in_command == rc4_pkg::CMD_SCHEDULE);
  assign take_cipher = take && (in_command == rc4_pkg::CMD_CIPHER);
  assign uc          = rc4_pkg::ucode_rom(pc_r);

  always_comb begin
    unique case (uc.cond)
      rc4_pkg::COND_NEVER:      cond_hit = 1'b0;
      rc4_pkg::COND_ALWAYS:     cond_hit = 1'b1;
      rc4_pkg::COND_I_NOT_LAST: cond_hit = !status.i_last;
      rc4_pkg::COND_OUT_BUSY:   cond_hit = !status.out_free;
      rc4_pkg::COND_NOT_SCHED:  cond_hit = !sched_r;
      default:                  cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    pc_nxt    = pc_r;
    sched_nxt = sched_r;
    if (idle) begin
      if (take_sched) begin
        pc_nxt    = rc4_pkg::PC_FILL;
        sched_nxt = 1'b1;
      end else if (take_cipher) begin
        pc_nxt = rc4_pkg::PC_CIPHER;
      end
    end else if (cond_hit) begin
      pc_nxt = uc.target;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= rc4_pkg::PC_FILL;
      sched_r <= 1'b0;
    end else begin
      pc_r    <= pc_nxt;
      sched_r <= sched_nxt;
    end
  end

  assign ctrl.uc       = uc;
  assign ctrl.key_wr   = take && (in_command == rc4_pkg::CMD_LOAD);
  assign ctrl.ld_data  = take_cipher;
  assign ctrl.sched_go = take_sched;

  `ASSERT_NXT(a_cipher_entry, clk, rst_n, take_cipher, pc_r == rc4_pkg::PC_CIPHER)
  `ASSERT_NXT(a_sched_entry, clk, rst_n, take_sched, (pc_r == rc4_pkg::PC_FILL) && sched_r)
  `ASSERT_NXT(a_emit_to_idle, clk, rst_n, uc.emit, pc_r == rc4_pkg::PC_IDLE)

endmodule

[hw/rtl/rc4_dp.sv]
`include "assert_macros.svh"

module rc4_dp #(
  parameter int KEY_MAX_BYTES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rc4_pkg::ctrl_t                      ctrl,
  input  rc4_pkg::in_beat_t                   in_data,
  input  logic [rc4_pkg::KLEN_W-1:0]          key_length,
  input  logic                                out_stall,
  output logic                                out_valid,
  output rc4_pkg::out_beat_t                  out_data,
  output rc4_pkg::status_t                    status
);

  localparam int KAW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam logic [rc4_pkg::KLEN_W-1:0] KEY_MAX_W = rc4_pkg::KLEN_W'(KEY_MAX_BYTES);

  logic [7:0]     perm_mem [256];
  logic [7:0]     key_mem  [KEY_MAX_BYTES];

  logic [7:0]     i_r, i_nxt;
  logic [7:0]     j_r, j_nxt;
  logic [KAW-1:0] k_r, k_nxt;
  logic [7:0]     si_r;
  logic [7:0]     sj_r;
  logic [7:0]     rdata_r;
  logic [7:0]     key_rdata_r;
  logic [7:0]     data_r;
  logic           out_valid_r;
  rc4_pkg::out_beat_t out_data_r;

  logic [7:0]     sum_j_rd;
  logic [7:0]     sum_j_rdkey;
  logic [7:0]     sum_t;
  logic [7:0]     addr;
  logic [7:0]     wdata;
  logic [rc4_pkg::KLEN_W-1:0] len_eff;
  logic [rc4_pkg::KLEN_W-1:0] k_inc;
  logic           key_in_range;

  assign sum_j_rd    = j_r + rdata_r;
  assign sum_j_rdkey = j_r + rdata_r + key_rdata_r;
  assign sum_t       = si_r + sj_r;

  always_comb begin
    unique case (ctrl.uc.addr_sel)
      rc4_pkg::ADDR_I:       addr = i_r;
      rc4_pkg::ADDR_I_INC:   addr = i_r + 8'd1;
      rc4_pkg::ADDR_J:       addr = j_r;
      rc4_pkg::ADDR_J_RD:    addr = sum_j_rd;
      rc4_pkg::ADDR_J_RDKEY: addr = sum_j_rdkey;
      rc4_pkg::ADDR_T:       addr = sum_t;
      default:               addr = i_r;
    endcase
  end

  always_comb begin
    unique case (ctrl.uc.wdata_sel)
      rc4_pkg::WD_RDATA: wdata = rdata_r;
      rc4_pkg::WD_SI:    wdata = si_r;
      rc4_pkg::WD_I:     wdata = i_r;
      default:           wdata = rdata_r;
    endcase
  end

  // The identity fill of a key schedule always starts from entry zero.
  always_comb begin
    unique case (ctrl.uc.i_op)
      rc4_pkg::I_HOLD: i_nxt = i_r;
      rc4_pkg::I_INC:  i_nxt = i_r + 8'd1;
      rc4_pkg::I_CLR:  i_nxt = 8'd0;
      default:         i_nxt = i_r;
    endcase
    if (ctrl.sched_go) begin
      i_nxt = 8'd0;
    end
  end

  always_comb begin
    unique case (ctrl.uc.j_op)
      rc4_pkg::J_HOLD:  j_nxt = j_r;
      rc4_pkg::J_RD:    j_nxt = sum_j_rd;
      rc4_pkg::J_RDKEY: j_nxt = sum_j_rdkey;
      rc4_pkg::J_CLR:   j_nxt = 8'd0;
      default:          j_nxt = j_r;
    endcase
  end

  // A zero length counts as one byte, and lengths beyond the store saturate.
  always_comb begin
    if (key_length == '0) begin
      len_eff = rc4_pkg::KLEN_W'(1);
    end else if (key_length > KEY_MAX_W) begin
      len_eff = KEY_MAX_W;
    end else begin
      len_eff = key_length;
    end
  end

  assign k_inc = rc4_pkg::KLEN_W'(k_r) + rc4_pkg::KLEN_W'(1);

  always_comb begin
    unique case (ctrl.uc.k_op)
      rc4_pkg::K_HOLD: k_nxt = k_r;
      rc4_pkg::K_CLR:  k_nxt = '0;
      rc4_pkg::K_ADV:  k_nxt = (k_inc == len_eff) ? '0 : k_inc[KAW-1:0];
      default:         k_nxt = k_r;
    endcase
  end

  assign key_in_range = ({1'b0, in_data.key_index} < KEY_MAX_W);

  always_ff @(posedge clk) begin
    if (ctrl.uc.mem_op == rc4_pkg::MEM_WR) begin
      perm_mem[addr] <= wdata;
    end
    if (ctrl.uc.mem_op == rc4_pkg::MEM_RD) begin
      rdata_r <= perm_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.key_wr && key_in_range) begin
      key_mem[in_data.key_index[KAW-1:0]] <= in_data.key_byte;
    end
    key_rdata_r <= key_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= 8'd0;
      j_r         <= 8'd0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      i_r <= i_nxt;
      j_r <= j_nxt;
      k_r <= k_nxt;
      if (ctrl.uc.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.uc.ld_si) begin
      si_r <= rdata_r;
    end
    if (ctrl.uc.ld_sj) begin
      sj_r <= rdata_r;
    end
    if (ctrl.ld_data) begin
      data_r <= in_data.data_byte;
    end
    if (ctrl.uc.emit) begin
      out_data_r.cipher_byte    <= data_r ^ rdata_r;
      out_data_r.keystream_byte <= rdata_r;
    end
  end

  assign status.i_last   = (i_r == 8'hff);
  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

  `ASSERT_IMP(a_no_overwrite, clk, rst_n, ctrl.uc.emit, !out_valid_r || !out_stall)
  `ASSERT_NXT(a_emit_shows, clk, rst_n, ctrl.uc.emit, out_valid_r)
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid_r && out_stall, out_valid_r && $stable(out_data_r))

endmodule
